/* hw/rtl/mlf_pkg.sv */
`default_nettype none

package mlf_pkg;

  // Number format: signed, FRAC_BITS fraction bits, held to VW bits
  localparam int FRAC_BITS = 16;
  localparam int VW        = 40;
  localparam int AW        = VW + 2;   // three-term sum before saturation
  localparam int HW        = VW / 2;   // multiplier operand half
  localparam int PW        = 2 * VW;   // full product

  // Field widths
  localparam int SMP_W      = 16;
  localparam int CUT_W      = 16;
  localparam int FS_W       = 32;
  localparam int RG_W       = 16;
  localparam int RG_FRAC    = 14;
  localparam int FS_FRAC    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [AW-1:0] acc_t;

  localparam val_t V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t V_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam val_t V_ONE = val_t'(longint'(1) << FRAC_BITS);

  // Filter constants, rounded to nearest
  localparam val_t K_015 = val_t'(((longint'(15) << FRAC_BITS) + 50) / 100);
  localparam val_t K_035 = val_t'(((longint'(35013) << FRAC_BITS) + 50000) / 100000);
  localparam val_t K_03  = val_t'(((longint'(3) << FRAC_BITS) + 5) / 10);

  // Stage output clamp limits
  localparam val_t CLAMP_HI = val_t'(longint'(32767) << FRAC_BITS);
  localparam val_t CLAMP_LO = val_t'(-(longint'(32768) << FRAC_BITS));

  localparam logic [FS_W-1:0] FREQ_SCALE_RST = FS_W'(225948);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQ_SCALE = 4'd0,
    REG_RES_GAIN   = 4'd1
  } cfg_reg_t;

  // Sequencer program: one product per step
  typedef enum logic [3:0] {
    ST_F   = 4'd0,
    ST_FF  = 4'd1,
    ST_T   = 4'd2,
    ST_FB  = 4'd3,
    ST_V   = 4'd4,
    ST_A   = 4'd5,
    ST_B   = 4'd6,
    ST_X   = 4'd7,
    ST_P1A = 4'd8,
    ST_P1B = 4'd9,
    ST_P2A = 4'd10,
    ST_P2B = 4'd11,
    ST_P3A = 4'd12,
    ST_P3B = 4'd13,
    ST_P4A = 4'd14,
    ST_P4B = 4'd15
  } step_t;

  // Sign extension to sum width
  function automatic acc_t sx(input val_t v);
    sx = {{(AW-VW){v[VW-1]}}, v};
  endfunction

  // Saturate a sum to VW bits
  function automatic val_t sat40(input acc_t v);
    if (v[AW-1:VW-1] == {(AW-VW+1){1'b0}} || v[AW-1:VW-1] == {(AW-VW+1){1'b1}}) begin
      sat40 = v[VW-1:0];
    end else begin
      sat40 = v[AW-1] ? V_MIN : V_MAX;
    end
  endfunction

  // Clamp to the 16-bit sample range
  function automatic val_t clamp16(input val_t v);
    if (v > CLAMP_HI) begin
      clamp16 = CLAMP_HI;
    end else if (v < CLAMP_LO) begin
      clamp16 = CLAMP_LO;
    end else begin
      clamp16 = v;
    end
  endfunction

  // Magnitude, unsigned so the most negative value fits
  function automatic logic [VW-1:0] mag(input val_t v);
    mag = v[VW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mlf_if.sv */
`default_nettype none

// Sample channel into the filter
interface mlf_in_if import mlf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_in;
  logic        [CUT_W-1:0] cutoff_hz;
  logic                    block_end;

  modport source (output valid, output sample_in, output cutoff_hz, output block_end,
                  input ready);
  modport sink   (input valid, input sample_in, input cutoff_hz, input block_end,
                  output ready);
endinterface

// Filtered sample channel
interface mlf_out_if import mlf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_out;
  logic                    block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

// Register write channel
interface mlf_cfg_if import mlf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/moog_ladder_lowpass_filter.sv */
`default_nettype none

// Four-pole resonant ladder low-pass, signed fixed point (40-bit values, FRAC_BITS
// fraction bits). Each item carries one 16-bit sample and a cutoff in Hz; one
// filtered sample comes out per item, with block_end copied through. All sixteen
// products of an item run one after another through a single shared 40x20
// multiplier, each passing through operand load, two partial products,
// combine/saturate and write-back; the result is then posted. A new item is
// accepted only once the previous result has been posted and the block is idle
// again. The result sits in an output register; if it has not been taken when
// the next result is done, the block waits. Registers: index 0 freq_scale
// (unsigned Q0.32 cutoff scale, reset 1.16/22050), index 1 resonance_gain
// (unsigned Q2.14, reset 0); write them only while the block is idle. Writes to
// other indexes are dropped.
module moog_ladder_lowpass_filter import mlf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  mlf_in_if.sink      feed,
  mlf_out_if.source   filtered,
  mlf_cfg_if.sink     cfg
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_MUL0 = 7'b0000100,
    S_MUL1 = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_WB   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  step_t  step;

  // Configuration
  logic [FS_W-1:0] freq_scale;
  logic [RG_W-1:0] resonance_gain;

  // Latched item
  logic signed [SMP_W-1:0] smp;
  logic        [CUT_W-1:0] cut;
  logic                    blk;

  // Per-item intermediates
  val_t f, g, ff, u, fb, x, tmp, pcur;
  acc_t acc;

  // Filter state
  val_t pole1_out, pole2_out, pole3_out, pole4_out;
  val_t pole1_prev_in, pole2_prev_in, pole3_prev_in, pole4_prev_in;

  // Multiplier unit
  logic [VW-1:0]    ua, ub;
  logic             neg;
  logic             cut_shift;
  logic [HW-1:0]    ub_half;
  logic [VW+HW-1:0] pp;
  logic [VW+HW-1:0] pp_lo, pp_hi;
  val_t             mres;

  // Output register
  logic                    out_valid;
  logic signed [SMP_W-1:0] out_sample;
  logic                    out_blk;

  // Derived values
  val_t             op_a, op_b;
  val_t             res_val;
  logic [VW-1:0]    res_wide;
  val_t             smp_val;
  logic [PW-1:0]    prod, shifted;
  logic             prod_sat;
  val_t             prod_r;
  val_t             pcur_cl;
  val_t             pcur_cl_sh;
  logic signed [SMP_W-1:0] q;
  logic             out_free;

  assign feed.ready     = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign filtered.valid = out_valid;
  assign filtered.sample_out    = out_sample;
  assign filtered.block_end_out = out_blk;

  assign res_wide = {{(VW-RG_W){1'b0}}, resonance_gain};
  assign res_val  = val_t'((res_wide << FRAC_BITS) >> RG_FRAC);
  assign smp_val  = val_t'({{(VW-SMP_W){smp[SMP_W-1]}}, smp} << FRAC_BITS);
  assign out_free = !out_valid || filtered.ready;

  // Shared 40x20 multiplier: low half of ub first, then high half
  assign ub_half = (state == S_MUL1) ? ub[VW-1:HW] : ub[HW-1:0];
  assign pp      = (VW+HW)'(ua) * (VW+HW)'(ub_half);

  // Operand select per program step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      ST_F: begin
        op_a = val_t'({{(VW-CUT_W){1'b0}}, cut});
        op_b = val_t'({{(VW-FS_W){1'b0}}, freq_scale});
      end
      ST_FF:  begin op_a = f;         op_b = f;             end
      ST_T:   begin op_a = K_015;     op_b = ff;            end
      ST_FB:  begin op_a = res_val;   op_b = u;             end
      ST_V:   begin op_a = pole4_out; op_b = fb;            end
      ST_A:   begin op_a = K_035;     op_b = ff;            end
      ST_B:   begin op_a = tmp;       op_b = ff;            end
      ST_X:   begin op_a = x;         op_b = tmp;           end
      ST_P1A: begin op_a = K_03;      op_b = pole1_prev_in; end
      ST_P1B: begin op_a = g;         op_b = pole1_out;     end
      ST_P2A: begin op_a = K_03;      op_b = pole2_prev_in; end
      ST_P2B: begin op_a = g;         op_b = pole2_out;     end
      ST_P3A: begin op_a = K_03;      op_b = pole3_prev_in; end
      ST_P3B: begin op_a = g;         op_b = pole3_out;     end
      ST_P4A: begin op_a = K_03;      op_b = pole4_prev_in; end
      ST_P4B: begin op_a = g;         op_b = pole4_out;     end
      default: begin op_a = '0;       op_b = '0;            end
    endcase
  end

  // Combine partial products, shift, detect overflow
  always_comb begin
    prod     = {{HW{1'b0}}, pp_lo} + {pp_hi, {HW{1'b0}}};
    shifted  = cut_shift ? (prod >> (FS_FRAC - FRAC_BITS)) : (prod >> FRAC_BITS);
    prod_sat = |shifted[PW-1:VW-1];
    prod_r   = val_t'(shifted[VW-1:0]);
  end

  // Final stage output, clamped and truncated toward zero
  always_comb begin
    pcur_cl    = clamp16(pcur);
    pcur_cl_sh = pcur_cl >>> FRAC_BITS;
    q = pcur_cl_sh[SMP_W-1:0]
        + ((pcur_cl[VW-1] && (|pcur_cl[FRAC_BITS-1:0])) ? SMP_W'(1) : SMP_W'(0));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_scale     <= FREQ_SCALE_RST;
      resonance_gain <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_FREQ_SCALE: freq_scale     <= cfg.data[FS_W-1:0];
        REG_RES_GAIN:   resonance_gain <= cfg.data[RG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_F;
      out_valid <= 1'b0;
    end else begin
      // Result register: set when posted, cleared when taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (feed.valid) begin
            state <= S_LOAD;
            step  <= ST_F;
          end
        end
        S_LOAD: state <= S_MUL0;
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_WB;
        S_WB: begin
          if (step == ST_P4B) begin
            state <= S_OUT;
          end else begin
            state <= S_LOAD;
            step  <= step_t'(step + 4'd1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Filter state (cleared on reset)
  always_ff @(posedge clk) begin
    if (rst) begin
      pole1_out     <= '0;
      pole2_out     <= '0;
      pole3_out     <= '0;
      pole4_out     <= '0;
      pole1_prev_in <= '0;
      pole2_prev_in <= '0;
      pole3_prev_in <= '0;
      pole4_prev_in <= '0;
    end else if (state == S_WB) begin
      case (step)
        ST_P1A: pole1_prev_in <= x;
        ST_P2A: begin
          pole1_out     <= pcur_cl;
          pole2_prev_in <= pcur_cl;
        end
        ST_P3A: begin
          pole2_out     <= pcur_cl;
          pole3_prev_in <= pcur_cl;
        end
        ST_P4A: begin
          pole3_out     <= pcur_cl;
          pole4_prev_in <= pcur_cl;
        end
        default: ;
      endcase
    end else if (state == S_OUT && out_free) begin
      pole4_out <= pcur_cl;
    end
  end

  // Datapath: item latch, multiplier phases, write-back, result capture
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        smp <= feed.sample_in;
        cut <= feed.cutoff_hz;
        blk <= feed.block_end;
      end
      S_LOAD: begin
        ua        <= mag(op_a);
        ub        <= mag(op_b);
        neg       <= op_a[VW-1] ^ op_b[VW-1];
        cut_shift <= (step == ST_F);
      end
      S_MUL0: pp_lo <= pp;
      S_MUL1: pp_hi <= pp;
      S_MUL2: begin
        if (prod_sat) begin
          mres <= neg ? V_MIN : V_MAX;
        end else begin
          mres <= neg ? -prod_r : prod_r;
        end
      end
      S_WB: begin
        case (step)
          ST_F: begin
            f <= mres;
            g <= sat40(sx(V_ONE) - sx(mres));
          end
          ST_FF:  ff   <= mres;
          ST_T:   u    <= sat40(sx(V_ONE) - sx(mres));
          ST_FB:  fb   <= mres;
          ST_V:   x    <= sat40(sx(smp_val) - sx(mres));
          ST_A:   tmp  <= mres;
          ST_B:   tmp  <= mres;
          ST_X:   x    <= mres;
          ST_P1A: acc  <= sx(x) + sx(mres);
          ST_P2A: acc  <= sx(pcur) + sx(mres);
          ST_P3A: acc  <= sx(pcur) + sx(mres);
          ST_P4A: acc  <= sx(pcur) + sx(mres);
          ST_P1B: pcur <= sat40(acc + sx(mres));
          ST_P2B: pcur <= sat40(acc + sx(mres));
          ST_P3B: pcur <= sat40(acc + sx(mres));
          ST_P4B: pcur <= sat40(acc + sx(mres));
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_sample <= q;
          out_blk    <= blk;
        end
      end
      default: ;
    endcase
  end

  // Stored fourth-pole output always lies inside the clamp range
  a_pole4_range: assert property (@(posedge clk) disable iff (rst)
    pole4_out >= CLAMP_LO && pole4_out <= CLAMP_HI)
    else $error("pole4_out outside clamp range");

  // An accepted item starts the program at its first step
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    feed.valid && feed.ready |=> state == S_LOAD && step == ST_F)
    else $error("item accepted without starting the sequence");

  // A finished result waits while the previous one is still held
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && out_valid && !filtered.ready |=> state == S_OUT)
    else $error("result posted over a pending one");

endmodule

`default_nettype wire
